// File: src/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the base64 stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam logic [7:0] NL_CODE    = 8'd10;
  localparam logic [6:0] PAD_INDEX  = 7'd64;
  localparam logic [7:0] MIN_LINE   = 8'd4;
  localparam logic [7:0] LINE_RESET = 8'd76;

  // group queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one complete or short final group of input bytes
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       fin;
  } grp_t;

  // standard alphabet, index 64 is the pad character
  function automatic logic [7:0] b64_char(input logic [6:0] idx);
    logic [7:0] c;
    case (idx) inside
      [7'd0:7'd25]:  c = 8'(idx) + 8'd65;
      [7'd26:7'd51]: c = 8'(idx) + 8'd71;
      [7'd52:7'd61]: c = 8'(idx) - 8'd4;
      7'd62:         c = 8'd43;
      7'd63:         c = 8'd47;
      default:       c = 8'd61;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts input bytes, holds pending bytes and pushes complete or short final groups.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  input  wire logic       q_full,
  output logic            push,
  output grp_t            push_grp
);

  logic [7:0] held_bytes [2];
  logic [1:0] held_count;
  logic [1:0] cnt;
  logic       accept;
  logic       group_done;

  assign in_stall   = q_full;
  assign accept     = in_valid && !in_stall;
  // a held count of three cannot arise, treat it as two
  assign cnt        = (held_count == 2'd3) ? 2'd2 : held_count;
  assign group_done = (cnt == 2'd2) || final_byte;
  assign push       = accept && group_done;

  always_comb begin
    push_grp.b0     = (cnt != 2'd0) ? held_bytes[0] : data_byte;
    push_grp.b1     = (cnt == 2'd2) ? held_bytes[1] :
                      ((cnt == 2'd1) ? data_byte : 8'd0);
    push_grp.b2     = (cnt == 2'd2) ? data_byte : 8'd0;
    push_grp.nbytes = cnt + 2'd1;
    push_grp.fin    = final_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      if (group_done) begin
        held_count <= 2'd0;
      end else begin
        held_count <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !group_done) begin
      held_bytes[cnt[0]] <= data_byte;
    end
  end

endmodule

`default_nettype wire

// File: src/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue that decouples the front from the character sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire grp_t push_grp,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output grp_t      head
);

  grp_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_grp;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("group pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("group popped from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: src/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Sequencer: one character or newline per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire grp_t       head,
  output logic            pop,
  input  wire logic [7:0] lim,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      char_code,
  output logic            run_last,
  output logic            stream_end
);

  logic [1:0] char_idx;
  logic [1:0] char_idx_next;
  logic       in_end;
  logic       in_end_next;
  logic [7:0] column_count;
  logic [7:0] column_count_next;
  logic       step;
  logic [6:0] idx [4];
  logic [7:0] emit_code;
  logic       emit_last;
  logic       emit_end;

  always_comb begin
    idx[0] = {1'b0, head.b0[7:2]};
    idx[1] = {1'b0, head.b0[1:0], head.b1[7:4]};
    idx[2] = {1'b0, head.b1[3:0], head.b2[7:6]};
    idx[3] = {1'b0, head.b2[5:0]};
    if (head.nbytes < 2'd2) begin
      idx[2] = PAD_INDEX;
    end
    if (head.nbytes < 2'd3) begin
      idx[3] = PAD_INDEX;
    end
  end

  assign step = head_valid && (!out_valid || !out_stall);

  always_comb begin
    char_idx_next     = char_idx;
    in_end_next       = in_end;
    column_count_next = column_count;
    emit_code         = NL_CODE;
    emit_last         = 1'b0;
    emit_end          = 1'b0;
    pop               = 1'b0;
    if (step) begin
      if (in_end) begin
        // trailing newline closes the stream
        emit_last         = 1'b1;
        emit_end          = 1'b1;
        column_count_next = 8'd0;
        in_end_next       = 1'b0;
        char_idx_next     = 2'd0;
        pop               = 1'b1;
      end else if (column_count >= lim) begin
        column_count_next = 8'd0;
      end else begin
        emit_code         = b64_char(idx[char_idx]);
        column_count_next = column_count + 8'd1;
        if (char_idx == 2'd3) begin
          char_idx_next = 2'd0;
          if (head.fin) begin
            in_end_next = 1'b1;
          end else begin
            emit_last = 1'b1;
            pop       = 1'b1;
          end
        end else begin
          char_idx_next = char_idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_idx     <= 2'd0;
      in_end       <= 1'b0;
      column_count <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      char_idx     <= char_idx_next;
      in_end       <= in_end_next;
      column_count <= column_count_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      char_code  <= emit_code;
      run_last   <= emit_last;
      stream_end <= emit_end;
    end
  end

  a_end_is_newline: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> run_last && (char_code == NL_CODE))
    else $error("stream end on something other than a closing newline");

  a_end_has_group: assert property (@(posedge clk) disable iff (rst)
    in_end |-> head_valid && head.fin)
    else $error("closing newline pending without a final group");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && run_last)
    else $error("group retired without its last character");

endmodule

`default_nettype wire

// File: src/base64_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Base64 encoder with line wrapping: bytes in, characters out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with data_byte and final_byte; set
// final_byte on the last byte of a stream. Output channel: out_valid /
// out_stall with char_code, run_last (last character caused by an input item)
// and stream_end (closing newline). cfg_we / cfg_data set the line length,
// written only while the block is idle; values below 4 act as 4. The block
// itself does not enforce the idle condition; the user is bound to it.
// Throughput: one character per cycle out of the back sequencer while the
// receiver does not stall, a newline being inserted when a line is full and
// after a final group to close the stream. Any byte is taken while the
// queue has room.
// The byte completing a group writes the group into the queue; its
// characters then pass in turn to the output register once the sequencer
// reaches the group and the receiver does not stall.
// in_stall rises while the two-entry group queue is full. When the receiver
// stalls, the output register holds its character and the queue fills
// behind it. Reset clears pending bytes, column and queue, and sets the line
// length to 76.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_core
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      char_code,
  output logic            run_last,
  output logic            stream_end
);

  logic [7:0] line_chars;
  logic [7:0] lim;
  logic       push;
  grp_t       push_grp;
  logic       pop;
  logic       q_full;
  logic       head_valid;
  grp_t       head;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_chars <= LINE_RESET;
    end else if (cfg_we) begin
      line_chars <= cfg_data;
    end
  end

  assign lim = (line_chars < MIN_LINE) ? MIN_LINE : line_chars;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .push_grp   (push_grp)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_grp   (push_grp),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .lim        (lim),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_code  (char_code),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

endmodule

`default_nettype wire
